[design/slf_pkg.sv]
// Shared types and constants for the sync/length frame receiver.
package slf_pkg;

  localparam int unsigned CAPTURE_BYTES = 30;

  localparam logic [7:0] SYNC_BYTE_0 = 8'hA5;
  localparam logic [7:0] SYNC_BYTE_1 = 8'h5A;

  localparam logic signed [31:0] TICK_LIMIT_POS = 32'sd220;
  localparam logic signed [31:0] TICK_LIMIT_NEG = -32'sd220;

  localparam logic [23:0] TIMEOUT_RESET = 24'd1000;

  // Item kind on the input tuser bit
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result kind on the output tuser bit
  localparam logic STATUS_FRAME   = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  localparam int unsigned TDATA_OUT_W = 296;

  typedef logic [CAPTURE_BYTES-1:0][7:0] cap_bytes_t;

  typedef struct packed {
    logic frame_done;
    logic timeout;
  } slf_event_t;

endpackage

[design/slf_parser.sv]
// Header search, payload capture and tick timeout state.
module slf_parser
  import slf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [23:0] timeout_ticks,
  output slf_event_t  evt,
  output cap_bytes_t  payload
);

  logic [2:0][7:0] history;
  logic            in_payload;
  logic [7:0]      payload_length;
  logic [7:0]      payload_count;
  cap_bytes_t      capture;
  logic [23:0]     elapsed;

  logic            hdr;
  logic            pay_active;
  logic [7:0]      len_eff;
  logic [7:0]      cnt_base;
  logic [7:0]      cnt_new;
  logic [23:0]     elapsed_next;
  logic            is_tick;

  assign is_tick      = (req_type == REQ_TICK);
  assign hdr          = (history[2] == SYNC_BYTE_0) && (history[1] == SYNC_BYTE_1);
  assign pay_active   = hdr || in_payload;
  assign len_eff      = hdr ? history[0] : payload_length;
  assign cnt_base     = hdr ? 8'd0 : payload_count;
  assign cnt_new      = cnt_base + 8'd1;
  assign elapsed_next = elapsed + 24'd1;

  // capture with the current byte merged in at its slot
  always_comb begin
    for (int i = 0; i < CAPTURE_BYTES; i++) begin
      payload[i] = (!is_tick && pay_active && cnt_base == 8'(i)) ? rx_byte : capture[i];
    end
  end

  assign evt.timeout    = is_tick && ((elapsed_next > timeout_ticks) || (elapsed_next == 24'd0));
  assign evt.frame_done = !is_tick && pay_active && (cnt_new == len_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      history        <= '0;
      in_payload     <= 1'b0;
      payload_length <= 8'd0;
      payload_count  <= 8'd0;
      capture        <= '0;
      elapsed        <= 24'd0;
    end else if (fire) begin
      if (evt.timeout || evt.frame_done) begin
        // new search; length and sums survive
        history       <= '0;
        in_payload    <= 1'b0;
        payload_count <= 8'd0;
        capture       <= '0;
        elapsed       <= 24'd0;
        if (evt.frame_done) begin
          payload_length <= len_eff;
        end
      end else if (is_tick) begin
        elapsed <= elapsed_next;
      end else begin
        capture        <= payload;
        in_payload     <= pay_active;
        payload_length <= len_eff;
        if (pay_active) begin
          payload_count <= cnt_new;
        end
        history <= {history[1], history[0], rx_byte};
      end
    end
  end

endmodule

[design/slf_unpack.sv]
// Field unpacking, tick range check, running totals and result register.
module slf_unpack
  import slf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  slf_event_t             evt,
  input  cap_bytes_t             payload,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  output logic                   m_tuser
);

  logic signed [31:0] raw_l;
  logic signed [31:0] raw_r;
  logic [8:0]         delta_l;
  logic [8:0]         delta_r;
  logic [47:0]        left_sum;
  logic [47:0]        right_sum;
  logic [47:0]        left_sum_next;
  logic [47:0]        right_sum_next;

  assign raw_l = $signed(payload[3:0]);
  assign raw_r = $signed(payload[7:4]);

  // out-of-range deltas count as zero
  assign delta_l = (raw_l > TICK_LIMIT_POS || raw_l < TICK_LIMIT_NEG) ? 9'd0 : raw_l[8:0];
  assign delta_r = (raw_r > TICK_LIMIT_POS || raw_r < TICK_LIMIT_NEG) ? 9'd0 : raw_r[8:0];

  assign left_sum_next  = left_sum + {{39{delta_l[8]}}, delta_l};
  assign right_sum_next = right_sum + {{39{delta_r[8]}}, delta_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= 48'd0;
      right_sum <= 48'd0;
      m_tvalid  <= 1'b0;
    end else begin
      if (fire && (evt.frame_done || evt.timeout)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fire && evt.frame_done) begin
        left_sum  <= left_sum_next;
        right_sum <= right_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && evt.frame_done) begin
      m_tuser <= STATUS_FRAME;
      m_tdata <= {6'd0, payload[29:24], payload[23:18], payload[17:12], payload[11:8],
                  right_sum_next, left_sum_next, delta_r, delta_l};
    end else if (fire && evt.timeout) begin
      m_tuser <= STATUS_TIMEOUT;
      m_tdata <= '0;
    end
  end

endmodule

[design/sync_length_frame_receiver_core.sv]
// Top level of the sync/length frame receiver: input register, parser, unpacker.
//
//  Channel  Dir  tdata (low bit up)                              tuser
//  s_*      in   rx_byte[7:0]                                    req_type
//  m_*      out  left_ticks[8:0] right_ticks[17:9]               frame_status
//                left_total[65:18] right_total[113:66]
//                battery_bits[145:114] accel_xyz[193:146]
//                gyro_xyz[241:194] mag_xyz[289:242], zero pad
//  cfg_*    in   timeout_ticks[23:0] on cfg_wdata, written when cfg_we
//
// One item per cycle sustained while no result waits on m_tready. An
// accepted item is held in the input register; when it fires, header,
// capture and timeout logic update state and, on frame end or timeout,
// load the result register, which drives m_*.
// rst is synchronous: search state, totals and the timeout register
// (back to 1000) are cleared together; no clearing pass.
// While a result waits on m_tready the input register still takes one item.
module sync_length_frame_receiver_core
  import slf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // rx_byte
  input  logic                   s_tuser,   // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // see table above
  output logic                   m_tuser,   // frame_status
  input  logic                   cfg_we,
  input  logic [23:0]            cfg_wdata  // timeout_ticks
);

  logic        in_valid;
  logic        in_type;
  logic [7:0]  in_byte;
  logic [23:0] timeout_ticks;
  logic        advance;
  logic        fire;
  slf_event_t  evt;
  cap_bytes_t  payload;

  // process when the result slot is free or draining this cycle
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  slf_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .req_type     (in_type),
    .rx_byte      (in_byte),
    .timeout_ticks(timeout_ticks),
    .evt          (evt),
    .payload      (payload)
  );

  slf_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .evt     (evt),
    .payload (payload),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
